FILE: hdl/lpr_pkg.sv
// Shared types and constants for the LRU page replacement block.
package lpr_pkg;

	localparam int CAP_W    = 5;
	localparam int MISS_W   = 32;
	localparam int EV_W     = 16;

	localparam logic [CAP_W-1:0]  CAP_RESET = 5'd4;
	localparam logic [MISS_W-1:0] MISS_MAX  = {MISS_W{1'b1}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_DONE
	} lpr_state_t;

	// Control for one update of the entry store.
	typedef struct packed {
		logic en;       // promote the selected entry
		logic clear;    // drop every entry (end of run)
		logic wr;       // write the request page into the selected entry
		logic age_all;  // age every valid entry, not only the younger ones
	} lpr_upd_t;

	// Status gathered over one scan.
	typedef struct packed {
		logic found;
		logic free_found;
		logic oldest_found;
	} lpr_scan_t;

endpackage

FILE: hdl/lpr_if.sv
// Channel interfaces: request, response and capacity write.
interface lpr_req_if #(parameter int PAGE_BITS = 16);
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] page;
	logic                 last_of_run;

	modport source (output valid, page, last_of_run, input ready);
	modport sink   (input valid, page, last_of_run, output ready);
endinterface

interface lpr_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic        evicted_valid;
	logic [15:0] evicted_page;
	logic [31:0] miss_total;

	modport source (output valid, hit, evicted_valid, evicted_page, miss_total, input ready);
	modport sink   (input valid, hit, evicted_valid, evicted_page, miss_total, output ready);
endinterface

interface lpr_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/lru_page_replacement.sv
// Top level of the LRU page replacement block: sequencer, capacity and miss registers.
//
// Fully associative page cache with least-recently-used replacement.
// Channels: req (sink) carries one page request per item with a last_of_run
// mark; rsp (source) returns one item per request with hit, eviction and the
// running miss total; cfg (sink, always ready) writes the capacity register.
// Each request scans every entry, one entry per cycle through a single page
// and rank compare fed by the registered read port of the page memory. The
// scan is followed by an update state, then a hand-off state that moves the
// result to the output register. A new request is taken only after the
// previous one has been handed off, since req is ready only while idle.
// The output register lets a new request start while a result still waits;
// if the receiver stalls, the next result holds in the hand-off state and no
// further request is taken until the register drains.
// Reset empties the cache, clears the miss total and sets capacity to 4.
// A request marked last_of_run empties the cache and the miss total once its
// result is formed; capacity is kept.
module lru_page_replacement #(
	parameter int MAX_ENTRIES = 16,
	parameter int PAGE_BITS   = 16
) (
	input logic         clk,
	input logic         arst_n,
	lpr_req_if.sink     req,
	lpr_rsp_if.source   rsp,
	lpr_cfg_if.sink     cfg
);
	import lpr_pkg::*;

	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int RANK_W = IDX_W;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	lpr_state_t state_q, state_d;

	logic [CAP_W-1:0]     cap_q;
	logic [MISS_W-1:0]    miss_q;
	logic [PAGE_BITS-1:0] page_q;
	logic                 last_q;
	logic [CNT_W-1:0]     cnt_q;

	// Result held between update and hand-off.
	logic                 res_hit_q, res_ev_q;
	logic [EV_W-1:0]      res_ev_page_q;
	logic [MISS_W-1:0]    res_miss_q;

	// Output register.
	logic                 rsp_vld_q;
	logic                 rsp_hit_q, rsp_ev_q;
	logic [EV_W-1:0]      rsp_ev_page_q;
	logic [MISS_W-1:0]    rsp_miss_q;

	logic                 req_acc;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic                 rd_vld_s1, rd_valid_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic [PAGE_BITS-1:0] rd_page_s1;
	logic [RANK_W-1:0]    rd_rank_s1;

	lpr_scan_t            sc;
	logic [IDX_W-1:0]     found_idx, free_idx, oldest_idx;
	logic [RANK_W-1:0]    found_rank;
	logic [PAGE_BITS-1:0] oldest_page;
	logic [CNT_W-1:0]     used;

	lpr_upd_t             upd;
	logic [IDX_W-1:0]     upd_idx;

	logic [CMP_W-1:0]     cap_x, cap_eff;
	logic                 use_free, do_evict;
	logic [MISS_W-1:0]    miss_inc;
	logic                 load_out;

	assign req_acc   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	// Sweep read addresses over every entry while scanning.
	assign rd_en   = (state_q == ST_SCAN) && (cnt_q < CNT_W'(MAX_ENTRIES));
	assign rd_addr = cnt_q[IDX_W-1:0];

	lpr_store #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.PAGE_BITS  (PAGE_BITS),
		.IDX_W      (IDX_W),
		.RANK_W     (RANK_W)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_vld_s1  (rd_vld_s1),
		.rd_idx_s1  (rd_idx_s1),
		.rd_page_s1 (rd_page_s1),
		.rd_valid_s1(rd_valid_s1),
		.rd_rank_s1 (rd_rank_s1),
		.upd        (upd),
		.upd_idx    (upd_idx),
		.upd_page   (page_q),
		.upd_limit  (found_rank)
	);

	lpr_scan #(
		.PAGE_BITS(PAGE_BITS),
		.IDX_W    (IDX_W),
		.RANK_W   (RANK_W),
		.CNT_W    (CNT_W)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (req_acc),
		.req_page   (page_q),
		.step_vld   (rd_vld_s1),
		.step_idx   (rd_idx_s1),
		.step_page  (rd_page_s1),
		.step_valid (rd_valid_s1),
		.step_rank  (rd_rank_s1),
		.flags      (sc),
		.found_idx  (found_idx),
		.found_rank (found_rank),
		.free_idx   (free_idx),
		.oldest_idx (oldest_idx),
		.oldest_page(oldest_page),
		.used       (used)
	);

	// Clamp capacity into 1..MAX_ENTRIES.
	assign cap_x = CMP_W'(cap_q);
	always_comb begin
		if (cap_x == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_x > CMP_W'(MAX_ENTRIES)) begin
			cap_eff = CMP_W'(MAX_ENTRIES);
		end else begin
			cap_eff = cap_x;
		end
	end

	// Replacement decision from the scan status.
	assign use_free = !sc.found && sc.free_found && (CMP_W'(used) < cap_eff);
	assign do_evict = !sc.found && !use_free && sc.oldest_found;
	assign miss_inc = (miss_q == MISS_MAX) ? miss_q : miss_q + 1'b1;
	assign load_out = (state_q == ST_DONE) && (!rsp_vld_q || rsp.ready);

	always_comb begin
		upd         = '0;
		upd.clear   = (state_q == ST_UPDATE) && last_q;
		upd.wr      = (state_q == ST_UPDATE) && (use_free || do_evict);
		upd.en      = (state_q == ST_UPDATE) && (sc.found || use_free || do_evict);
		upd.age_all = !sc.found;
		if (sc.found) begin
			upd_idx = found_idx;
		end else if (use_free) begin
			upd_idx = free_idx;
		end else begin
			upd_idx = oldest_idx;
		end
	end

	// Sequencer: idle, scan, update, hand off.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == CNT_W'(MAX_ENTRIES)) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: scan counter, capacity, miss total, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			cap_q <= CAP_RESET;
			miss_q <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (req_acc) begin
				cnt_q <= '0;
			end else if (rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cfg.valid) begin
				cap_q <= cfg.data;
			end
			if (state_q == ST_UPDATE) begin
				if (last_q) begin
					miss_q <= '0;
				end else if (!sc.found) begin
					miss_q <= miss_inc;
				end
			end
			if (load_out) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers: request capture, result, output.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			page_q <= req.page;
			last_q <= req.last_of_run;
		end
		if (state_q == ST_UPDATE) begin
			res_hit_q <= sc.found;
			res_ev_q <= do_evict;
			res_ev_page_q <= do_evict ? EV_W'(oldest_page) : '0;
			res_miss_q <= sc.found ? miss_q : miss_inc;
		end
		if (load_out) begin
			rsp_hit_q <= res_hit_q;
			rsp_ev_q <= res_ev_q;
			rsp_ev_page_q <= res_ev_page_q;
			rsp_miss_q <= res_miss_q;
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.hit           = rsp_hit_q;
	assign rsp.evicted_valid = rsp_ev_q;
	assign rsp.evicted_page  = rsp_ev_page_q;
	assign rsp.miss_total    = rsp_miss_q;

	// A hit never evicts.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.hit && rsp.evicted_valid))
		else $error("hit reported together with an eviction");

	// Evicted page reads zero when nothing was evicted.
	a_ev_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.evicted_valid) |-> (rsp.evicted_page == '0))
		else $error("evicted page nonzero without eviction");

	// No second request is taken while one is in flight.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req.ready)
		else $error("request channel ready right after an accept");

	// Store is never written while the scan is reading it.
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !(upd.en || upd.clear))
		else $error("store update during scan");

endmodule

FILE: hdl/lpr_store.sv
// Entry store: page memory, valid bits and per-entry recency rank cells.
module lpr_store #(
	parameter int MAX_ENTRIES = 16,
	parameter int PAGE_BITS   = 16,
	parameter int IDX_W       = 4,
	parameter int RANK_W      = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [IDX_W-1:0]     rd_addr,
	output logic                 rd_vld_s1,
	output logic [IDX_W-1:0]     rd_idx_s1,
	output logic [PAGE_BITS-1:0] rd_page_s1,
	output logic                 rd_valid_s1,
	output logic [RANK_W-1:0]    rd_rank_s1,
	input  lpr_pkg::lpr_upd_t    upd,
	input  logic [IDX_W-1:0]     upd_idx,
	input  logic [PAGE_BITS-1:0] upd_page,
	input  logic [RANK_W-1:0]    upd_limit
);
	import lpr_pkg::*;

	logic [PAGE_BITS-1:0] page_mem [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [RANK_W-1:0]      rank_q [MAX_ENTRIES];

	// Page memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (upd.wr && !upd.clear) begin
			page_mem[upd_idx] <= upd_page;
		end
		if (rd_en) begin
			rd_page_s1 <= page_mem[rd_addr];
			rd_valid_s1 <= valid_q[rd_addr];
			rd_rank_s1 <= rank_q[rd_addr];
			rd_idx_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	// Each cell ages or resets its own rank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (upd.clear) begin
			valid_q <= '0;
		end else if (upd.en) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (IDX_W'(i) == upd_idx) begin
					rank_q[i] <= '0;
					if (upd.wr) begin
						valid_q[i] <= 1'b1;
					end
				end else if (valid_q[i] && (upd.age_all || rank_q[i] < upd_limit)) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
		end
	end

endmodule

FILE: hdl/lpr_scan.sv
// Scan unit: one entry per cycle through a shared compare, accumulating the lookup status.
module lpr_scan #(
	parameter int PAGE_BITS = 16,
	parameter int IDX_W     = 4,
	parameter int RANK_W    = 4,
	parameter int CNT_W     = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [PAGE_BITS-1:0] req_page,
	input  logic                 step_vld,
	input  logic [IDX_W-1:0]     step_idx,
	input  logic [PAGE_BITS-1:0] step_page,
	input  logic                 step_valid,
	input  logic [RANK_W-1:0]    step_rank,
	output lpr_pkg::lpr_scan_t   flags,
	output logic [IDX_W-1:0]     found_idx,
	output logic [RANK_W-1:0]    found_rank,
	output logic [IDX_W-1:0]     free_idx,
	output logic [IDX_W-1:0]     oldest_idx,
	output logic [PAGE_BITS-1:0] oldest_page,
	output logic [CNT_W-1:0]     used
);
	import lpr_pkg::*;

	lpr_scan_t           flags_q;
	logic [IDX_W-1:0]     found_idx_q, free_idx_q, oldest_idx_q;
	logic [RANK_W-1:0]    found_rank_q, oldest_rank_q;
	logic [PAGE_BITS-1:0] oldest_page_q;
	logic [CNT_W-1:0]     used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			used_q <= '0;
		end else if (start) begin
			flags_q <= '0;
			used_q <= '0;
		end else if (step_vld) begin
			if (step_valid) begin
				used_q <= used_q + 1'b1;
				if (step_page == req_page) begin
					flags_q.found <= 1'b1;
				end
				if (!flags_q.oldest_found || step_rank > oldest_rank_q) begin
					flags_q.oldest_found <= 1'b1;
				end
			end else if (!flags_q.free_found) begin
				flags_q.free_found <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_vld && !start) begin
			if (step_valid) begin
				if (step_page == req_page) begin
					found_idx_q <= step_idx;
					found_rank_q <= step_rank;
				end
				if (!flags_q.oldest_found || step_rank > oldest_rank_q) begin
					oldest_idx_q <= step_idx;
					oldest_rank_q <= step_rank;
					oldest_page_q <= step_page;
				end
			end else if (!flags_q.free_found) begin
				free_idx_q <= step_idx;
			end
		end
	end

	assign flags       = flags_q;
	assign found_idx   = found_idx_q;
	assign found_rank  = found_rank_q;
	assign free_idx    = free_idx_q;
	assign oldest_idx  = oldest_idx_q;
	assign oldest_page = oldest_page_q;
	assign used        = used_q;

endmodule
